@@ src/eicc_pkg.sv @@
// ----------------------------------------------------------------------------
// eicc_pkg
// Shared types, constants and the byte-wise CRC-16/CCITT-FALSE step.
// ----------------------------------------------------------------------------
package eicc_pkg;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    localparam int NAME_IDX_W = 5;
    localparam int MAX_OUT    = 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHOW
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic absorb;      // input beat accepted
        logic start_fail;  // present the single failure result
        logic start_name;  // begin name readout at index 0
        logic inc_idx;     // advance to next name byte
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic fail;        // valid with an accepted last beat
        logic last_result; // current result is the final one of the run
    } t_dp_stat;

    // one byte of MSB-first CRC, eight shift steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ src/eeprom_image_crc_checker_core.sv @@
// ----------------------------------------------------------------------------
// eeprom_image_crc_checker_core
// EEPROM image CRC-16/CCITT-FALSE check and name field extraction.
// ----------------------------------------------------------------------------
// Image bytes are taken one beat per cycle while the block is collecting.
// The CRC (poly 0x1021, init 0xFFFF, MSB first, no final xor) runs over
// bytes 0 to CRC_OFFSET-1, the stored CRC is taken little-endian from bytes
// CRC_OFFSET and CRC_OFFSET+1, and the name field is written into a small
// RAM as it streams by. Bytes at position IMAGE_BYTES and beyond are ignored
// but their last mark still closes the image. On the beat marked last the
// input stalls and results go out: a short image or CRC mismatch gives one
// beat (valid 0, byte 0) in the cycle after the last byte; a good image gives
// min(NAME_LEN, 32) name beats, each going through a RAM read state and a
// presentation state plus any output stall, the final name byte forced to 0.
// Input is accepted again the cycle after the final result beat is taken.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module eeprom_image_crc_checker_core #(
    parameter int IMAGE_BYTES = 128,
    parameter int CRC_OFFSET  = 126,
    parameter int NAME_OFFSET = 94,
    parameter int NAME_LEN    = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // image byte channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_last_byte,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_name_byte,
    output logic [eicc_pkg::NAME_IDX_W-1:0] o_name_index,
    output logic                            o_image_valid,
    output logic                            o_last_result
);
    import eicc_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: collect beats, then step through results
    eicc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_byte (i_last_byte),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    // CRC, position, stored CRC and name RAM
    eicc_datapath #(
        .IMAGE_BYTES (IMAGE_BYTES),
        .CRC_OFFSET  (CRC_OFFSET),
        .NAME_OFFSET (NAME_OFFSET),
        .NAME_LEN    (NAME_LEN)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_name_byte   (o_name_byte),
        .o_name_index  (o_name_index),
        .o_image_valid (o_image_valid),
        .o_last_result (o_last_result)
    );

endmodule

@@ src/eicc_ram.sv @@
// ----------------------------------------------------------------------------
// eicc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module eicc_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 32,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/eicc_datapath.sv @@
// ----------------------------------------------------------------------------
// eicc_datapath
// Position counter, running CRC, stored CRC capture, name buffer and
// result fields.
// ----------------------------------------------------------------------------
module eicc_datapath #(
    parameter int IMAGE_BYTES = 128,
    parameter int CRC_OFFSET  = 126,
    parameter int NAME_OFFSET = 94,
    parameter int NAME_LEN    = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  eicc_pkg::t_dp_cmd                    i_cmd,
    output eicc_pkg::t_dp_stat                   o_stat,
    input  logic [7:0]                           i_data_byte,
    input  logic                                 i_last_byte,
    output logic [7:0]                           o_name_byte,
    output logic [eicc_pkg::NAME_IDX_W-1:0]      o_name_index,
    output logic                                 o_image_valid,
    output logic                                 o_last_result
);
    import eicc_pkg::*;

    localparam int AddrW   = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
    localparam int NOut    = (NAME_LEN < MAX_OUT) ? NAME_LEN : MAX_OUT;
    localparam logic [7:0] ImageEnd = 8'(IMAGE_BYTES);
    localparam logic [7:0] CrcLo    = 8'(CRC_OFFSET);
    localparam logic [7:0] CrcHi    = 8'(CRC_OFFSET + 1);
    localparam logic [7:0] NameLo   = 8'(NAME_OFFSET);
    localparam logic [8:0] NameEnd  = 9'(NAME_OFFSET + NAME_LEN);
    localparam logic [NAME_IDX_W-1:0] IdxLast = NAME_IDX_W'(NOut - 1);

    logic [7:0]            r_pos;
    logic [15:0]           r_crc;
    logic [15:0]           r_stored;
    logic [7:0]            n_pos;
    logic [15:0]           n_crc;
    logic [15:0]           n_stored;
    logic                  in_image;
    logic                  name_we;
    logic [AddrW-1:0]      name_waddr;
    logic [7:0]            name_rdata;
    logic                  r_fail;
    logic [NAME_IDX_W-1:0] r_idx;
    logic                  idx_last;

    assign in_image = (r_pos < ImageEnd);

    always_comb begin
        n_crc    = r_crc;
        n_stored = r_stored;
        if (in_image && (r_pos < CrcLo)) begin
            n_crc = crc16_byte(r_crc, i_data_byte);
        end
        if (in_image && (r_pos == CrcLo)) begin
            n_stored = {r_stored[15:8], i_data_byte};
        end
        if (in_image && (r_pos == CrcHi)) begin
            n_stored = {i_data_byte, r_stored[7:0]};
        end
        n_pos = (r_pos != 8'hFF) ? r_pos + 8'd1 : 8'hFF;
    end

    assign o_stat.fail = (n_pos < ImageEnd) || (n_stored != n_crc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 8'd0;
            r_crc    <= CRC_INIT;
            r_stored <= 16'h0000;
        end else if (i_cmd.absorb) begin
            if (i_last_byte) begin
                r_pos    <= 8'd0;
                r_crc    <= CRC_INIT;
                r_stored <= 16'h0000;
            end else begin
                r_pos    <= n_pos;
                r_crc    <= n_crc;
                r_stored <= n_stored;
            end
        end
    end

    // name field capture
    assign name_we    = i_cmd.absorb && in_image && (r_pos >= NameLo)
                        && ({1'b0, r_pos} < NameEnd);
    assign name_waddr = AddrW'(r_pos - NameLo);

    eicc_ram #(
        .WIDTH (8),
        .DEPTH (NAME_LEN)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (name_we),
        .i_waddr (name_waddr),
        .i_wdata (i_data_byte),
        .i_raddr (AddrW'(r_idx)),
        .o_rdata (name_rdata)
    );

    // result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_fail) begin
            r_fail <= 1'b1;
            r_idx  <= '0;
        end else if (i_cmd.start_name) begin
            r_fail <= 1'b0;
            r_idx  <= '0;
        end else if (i_cmd.inc_idx) begin
            r_idx  <= r_idx + NAME_IDX_W'(1);
        end
    end

    assign idx_last           = (r_idx == IdxLast);
    assign o_stat.last_result = r_fail || idx_last;
    assign o_name_byte        = (r_fail || idx_last) ? 8'h00 : name_rdata;
    assign o_name_index       = r_idx;
    assign o_image_valid      = !r_fail;
    assign o_last_result      = r_fail || idx_last;

endmodule

@@ src/eicc_ctrl.sv @@
// ----------------------------------------------------------------------------
// eicc_ctrl
// Sequencer: absorbs image beats, then walks out the result beats.
// ----------------------------------------------------------------------------
module eicc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_last_byte,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output eicc_pkg::t_dp_cmd  o_cmd,
    input  eicc_pkg::t_dp_stat i_stat
);
    import eicc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.absorb = i_in_valid;
                if (i_in_valid && i_last_byte) begin
                    if (i_stat.fail) begin
                        o_cmd.start_fail = 1'b1;
                        n_state          = S_SHOW;
                    end else begin
                        o_cmd.start_name = 1'b1;
                        n_state          = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_SHOW;
            end
            S_SHOW: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    if (i_stat.last_result) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.inc_idx = 1'b1;
                        n_state       = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/eicc_checker.sv @@
// ----------------------------------------------------------------------------
// eicc_checker
// Port-level assertions for the checker core, bound to the top level.
// ----------------------------------------------------------------------------
module eicc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [7:0]                      o_name_byte,
    input logic [eicc_pkg::NAME_IDX_W-1:0] o_name_index,
    input logic                            o_image_valid,
    input logic                            o_last_result
);
    import eicc_pkg::*;

    // no image beat is taken while a result is on offer
    a_no_accept_during_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while result pending");

    // stalled result beat holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_name_byte)
            && $stable(o_name_index) && $stable(o_image_valid) && $stable(o_last_result))
        else $error("stalled result changed");

    // failure is a single zero beat
    a_fail_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_image_valid |-> o_last_result && (o_name_byte == 8'h00)
            && (o_name_index == '0))
        else $error("bad failure result");

    // name beats step by one index after a read gap
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_result
            |=> !o_out_valid ##1 o_out_valid
                && (o_name_index == NAME_IDX_W'($past(o_name_index, 2) + 1'b1)))
        else $error("name index did not advance");

endmodule

bind eeprom_image_crc_checker_core eicc_checker u_eicc_checker (.*);

@@ verif/tb_eeprom_image_crc_checker_core.sv @@
// ----------------------------------------------------------------------------
// tb_eeprom_image_crc_checker_core
// Self-checking bench for the EEPROM image CRC checker and name extractor.
// ----------------------------------------------------------------------------
// Whole images are streamed in one byte per beat. A table of directed images
// runs first: short images, a failing image right after reset, all-zero,
// all-one and alternating fills, bad stored and bad data CRCs, and images
// that run past the end up to and beyond the saturation of the position
// counter. Random images follow, mostly well formed with good CRCs and
// random content, the rest short, corrupted or overlong. Every accepted
// input beat feeds a local shadow of the block that predicts the result
// beats; every accepted result beat is compared field by field against the
// oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_eeprom_image_crc_checker_core;

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------------
    // Configuration of the instance and of the run
    // ------------------------------------------------------------------------
    localparam int IMAGE_BYTES = 128;
    localparam int CRC_OFFSET  = 126;
    localparam int NAME_OFFSET = 94;
    localparam int NAME_LEN    = 32;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int MAX_IMAGE      = 300;   // longest image ever sent
    localparam int RANDOM_ITEMS   = 150;   // in-image beats of the random part
    localparam int RANDOM_RESULTS = 96;    // result beats the random part wants
    localparam int MAX_GAP        = 12;
    localparam int MAX_BURST      = 40;
    localparam int HOLD_CYCLES    = 200;   // one long receiver hold-off
    // a good image drains through a read and a presentation state per name beat, plus stalls
    localparam int DRAIN_CYCLES   = 2 * eicc_pkg::MAX_OUT + 16;
    localparam int CYCLE_LIMIT    = 500_000;

    // ------------------------------------------------------------------------
    // Types
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [7:0]                      name_byte;
        logic [eicc_pkg::NAME_IDX_W-1:0] name_index;
        logic                            image_valid;
        logic                            last_result;
    } t_name_beat;

    typedef enum logic [2:0] {
        FILL_ZERO,
        FILL_ONES,
        FILL_ALT,
        FILL_ASCII,
        FILL_RANDOM
    } t_fill;

    typedef enum logic [1:0] {
        CRC_GOOD,        // correct checksum at the CRC offset
        CRC_BAD_STORED,  // one bit of the stored checksum flipped
        CRC_BAD_DATA     // one bit of a covered byte flipped after the CRC
    } t_crc_mode;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    typedef struct packed {
        logic [8:0] len;
        t_fill      fill;
        t_crc_mode  crc_mode;
        logic       has_typed;   // expected result typed in below
        t_name_beat typed;
    } t_image_case;

    // short image or CRC mismatch: a single beat, byte 0, index 0, valid 0, last
    localparam t_name_beat FAIL_BEAT = '{
        name_byte: 8'h00, name_index: '0, image_valid: 1'b0, last_result: 1'b1
    };
    localparam t_name_beat NO_BEAT = '0;

    // ------------------------------------------------------------------------
    // Directed images. Rows without a typed result go to the predictor.
    // ------------------------------------------------------------------------
    localparam int DIRECTED_ROWS = 14;
    localparam t_image_case DIRECTED [DIRECTED_ROWS] = '{
        '{9'd1,   FILL_ZERO,   CRC_GOOD,       1'b1, FAIL_BEAT}, // lone last beat
        '{9'd2,   FILL_ONES,   CRC_GOOD,       1'b1, FAIL_BEAT},
        '{9'd127, FILL_RANDOM, CRC_GOOD,       1'b1, FAIL_BEAT}, // one byte short
        '{9'd128, FILL_ZERO,   CRC_GOOD,       1'b0, NO_BEAT},
        '{9'd128, FILL_ONES,   CRC_GOOD,       1'b0, NO_BEAT},
        '{9'd128, FILL_ASCII,  CRC_GOOD,       1'b0, NO_BEAT},
        '{9'd128, FILL_RANDOM, CRC_BAD_STORED, 1'b1, FAIL_BEAT},
        '{9'd128, FILL_RANDOM, CRC_BAD_DATA,   1'b1, FAIL_BEAT},
        '{9'd129, FILL_ALT,    CRC_GOOD,       1'b0, NO_BEAT},   // tail ignored
        '{9'd255, FILL_RANDOM, CRC_GOOD,       1'b0, NO_BEAT},
        '{9'd256, FILL_RANDOM, CRC_GOOD,       1'b0, NO_BEAT},   // counter saturates
        '{9'd300, FILL_ONES,   CRC_GOOD,       1'b0, NO_BEAT},
        '{9'd300, FILL_RANDOM, CRC_BAD_STORED, 1'b1, FAIL_BEAT},
        '{9'd128, FILL_RANDOM, CRC_GOOD,       1'b0, NO_BEAT}    // fresh run after all
    };

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic [7:0]                      i_data_byte;
    logic                            i_last_byte;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic [7:0]                      o_name_byte;
    logic [eicc_pkg::NAME_IDX_W-1:0] o_name_index;
    logic                            o_image_valid;
    logic                            o_last_result;

    eeprom_image_crc_checker_core #(
        .IMAGE_BYTES (IMAGE_BYTES),
        .CRC_OFFSET  (CRC_OFFSET),
        .NAME_OFFSET (NAME_OFFSET),
        .NAME_LEN    (NAME_LEN)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_name_byte   (o_name_byte),
        .o_name_index  (o_name_index),
        .o_image_valid (o_image_valid),
        .o_last_result (o_last_result)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shadow state of the block
    // ------------------------------------------------------------------------
    logic [7:0]  img_pos;
    logic [15:0] img_crc;
    logic [15:0] img_stored;
    logic [7:0]  name_shadow [NAME_LEN];

    t_name_beat  expected_name_beats [$];
    int          results_predicted = 0;
    int          mismatch_count    = 0;
    int          cycle_count       = 0;

    // set by the sender for the image on the wire
    logic        use_typed  = 1'b0;
    t_name_beat  typed_beat = NO_BEAT;

    logic        in_random_phase = 1'b0;
    logic        gaps_on         = 1'b1;
    int          burst_left      = 0;
    logic [7:0]  image_buf [MAX_IMAGE];

    // MSB-first CRC-16/CCITT-FALSE, one data bit per step
    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc,
                                                   input logic [7:0]  b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ eicc_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic restart_image();
        img_pos    = 8'd0;
        img_crc    = eicc_pkg::CRC_INIT;
        img_stored = 16'h0000;
    endtask

    // absorb one accepted beat; on the last one queue the result beats
    task automatic predict_image_byte(input logic [7:0] b, input logic last);
        int         p;
        int         n;
        t_name_beat beat;
        p = int'(img_pos);
        if (p < IMAGE_BYTES) begin
            if (p < CRC_OFFSET) begin
                img_crc = crc_ccitt_step(img_crc, b);
            end
            if (p == CRC_OFFSET) begin
                img_stored[7:0] = b;
            end
            if (p == CRC_OFFSET + 1) begin
                img_stored[15:8] = b;
            end
            if (p >= NAME_OFFSET && p < NAME_OFFSET + NAME_LEN) begin
                name_shadow[p - NAME_OFFSET] = b;
            end
        end
        if (p < 255) begin
            img_pos = 8'(p + 1);
        end
        if (last) begin
            if (use_typed) begin
                expected_name_beats.push_back(typed_beat);
                results_predicted++;
            end else if (img_pos < IMAGE_BYTES || img_stored != img_crc) begin
                expected_name_beats.push_back(FAIL_BEAT);
                results_predicted++;
            end else begin
                n = (NAME_LEN < eicc_pkg::MAX_OUT) ? NAME_LEN : eicc_pkg::MAX_OUT;
                for (int k = 0; k < n; k++) begin
                    // final name byte is always forced to a terminator
                    beat.name_byte   = (k == n - 1) ? 8'h00 : name_shadow[k];
                    beat.name_index  = k[eicc_pkg::NAME_IDX_W-1:0];
                    beat.image_valid = 1'b1;
                    beat.last_result = (k == n - 1);
                    expected_name_beats.push_back(beat);
                end
                results_predicted += n;
            end
            restart_image();
        end
    endtask

    function automatic void check_field(input string      field,
                                        input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h",
                     $time, field, exp_v, act_v);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : beat_monitor
        t_name_beat exp_beat;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_image_byte(i_data_byte, i_last_byte);
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_name_beats.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result beat, expected none actual %0h/%0d/%0b/%0b",
                             $time, o_name_byte, o_name_index, o_image_valid,
                             o_last_result);
                end else begin
                    exp_beat = expected_name_beats.pop_front();
                    check_field("name_byte",   exp_beat.name_byte,   o_name_byte);
                    check_field("name_index",  8'(exp_beat.name_index), 8'(o_name_index));
                    check_field("image_valid", 8'(exp_beat.image_valid), 8'(o_image_valid));
                    check_field("last_result", 8'(exp_beat.last_result), 8'(o_last_result));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern is redrawn at random from four modes. The first
    // result of the random part triggers one long hold-off, which backs the
    // block up until its input stalls while the sender keeps offering.
    // ------------------------------------------------------------------------
    initial begin : receiver
        t_stall_mode mode;
        int          mode_left;
        int          hold_cnt;
        int          phase;
        logic        hold_done;
        mode        = STALL_NONE;
        mode_left   = 0;
        phase       = 0;
        hold_done   = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (in_random_phase && !hold_done && o_out_valid) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) begin
                    @(negedge i_clk);
                end
            end
            if (mode_left == 0) begin
                case ($urandom_range(0, 3))
                    0: mode = STALL_NONE;
                    1: mode = STALL_LIGHT;
                    2: mode = STALL_HEAVY;
                    default: mode = STALL_PERIODIC;
                endcase
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            phase++;
            case (mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                default:     i_out_stall <= ((phase % 5) < 2);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // fill the image buffer and place (or break) the stored checksum
    task automatic build_image(input t_fill fill, input t_crc_mode crc_mode);
        logic [15:0] crc;
        int          idx;
        for (int i = 0; i < MAX_IMAGE; i++) begin
            case (fill)
                FILL_ZERO: image_buf[i] = 8'h00;
                FILL_ONES: image_buf[i] = 8'hFF;
                FILL_ALT:  image_buf[i] = i[0] ? 8'h55 : 8'hAA;
                FILL_ASCII: begin
                    if (i >= NAME_OFFSET && i < NAME_OFFSET + NAME_LEN) begin
                        image_buf[i] = 8'($urandom_range(8'h20, 8'h7E));
                    end else begin
                        image_buf[i] = 8'($urandom);
                    end
                end
                default:   image_buf[i] = 8'($urandom);
            endcase
        end
        crc = eicc_pkg::CRC_INIT;
        for (int i = 0; i < CRC_OFFSET; i++) begin
            crc = crc_ccitt_step(crc, image_buf[i]);
        end
        // stored little-endian
        image_buf[CRC_OFFSET]     = crc[7:0];
        image_buf[CRC_OFFSET + 1] = crc[15:8];
        case (crc_mode)
            CRC_BAD_STORED: begin
                idx = CRC_OFFSET + $urandom_range(0, 1);
                image_buf[idx] = image_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            CRC_BAD_DATA: begin
                idx = $urandom_range(0, CRC_OFFSET - 1);
                image_buf[idx] = image_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            default: ;
        endcase
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer_beat(input logic [7:0] b, input logic last);
        if (gaps_on && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(negedge i_clk);
            burst_left = $urandom_range(1, MAX_BURST);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic send_image(input int len, input logic has_typed,
                              input t_name_beat typed);
        use_typed  = has_typed;
        typed_beat = typed;
        // some images go without any sender gaps
        gaps_on    = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < len; i++) begin
            offer_beat(image_buf[i], i == len - 1);
        end
    endtask

    task automatic wait_results_drained();
        while (expected_name_beats.size() != 0) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int        len;
        int        pick;
        int        rand_bytes;
        int        rand_base;
        int        img_count;
        t_fill     fill;
        t_crc_mode mode;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_data_byte = 8'h00;
        i_last_byte = 1'b0;
        restart_image();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed images
        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            build_image(DIRECTED[row].fill, DIRECTED[row].crc_mode);
            send_image(int'(DIRECTED[row].len), DIRECTED[row].has_typed,
                       DIRECTED[row].typed);
        end

        // hold the sender until every directed result is out
        i_in_valid <= 1'b0;
        wait_results_drained();
        @(negedge i_clk);

        // random images
        in_random_phase = 1'b1;
        rand_bytes      = 0;
        rand_base       = results_predicted;
        img_count       = 0;
        while (rand_bytes < RANDOM_ITEMS ||
               results_predicted - rand_base < RANDOM_RESULTS) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                len  = IMAGE_BYTES;
                mode = CRC_GOOD;
            end else if (pick < 60) begin
                len  = $urandom_range(IMAGE_BYTES + 1, MAX_IMAGE);
                mode = CRC_GOOD;
            end else if (pick < 70) begin
                len  = IMAGE_BYTES;
                mode = CRC_BAD_STORED;
            end else if (pick < 75) begin
                len  = IMAGE_BYTES;
                mode = CRC_BAD_DATA;
            end else if (pick < 95) begin
                // truncated image, mostly very short
                len  = $urandom_range(0, 1) ? $urandom_range(1, 12)
                                            : $urandom_range(1, IMAGE_BYTES - 1);
                mode = CRC_GOOD;
            end else begin
                len  = $urandom_range(IMAGE_BYTES + 1, MAX_IMAGE);
                mode = CRC_BAD_STORED;
            end
            case ($urandom_range(0, 9))
                0:       fill = FILL_ZERO;
                1:       fill = FILL_ONES;
                2:       fill = FILL_ALT;
                3, 4:    fill = FILL_ASCII;
                default: fill = FILL_RANDOM;
            endcase
            build_image(fill, mode);
            send_image(len, 1'b0, NO_BEAT);
            // bytes past the image end are ignored, not counted
            rand_bytes += (len < IMAGE_BYTES) ? len : IMAGE_BYTES;
            img_count++;
            if (img_count == 3) begin
                i_in_valid <= 1'b0;
                wait_results_drained();
                @(negedge i_clk);
            end
        end

        i_in_valid <= 1'b0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (expected_name_beats.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d result beats expected, none arrived",
                     $time, expected_name_beats.size());
        end

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/eicc_pkg.sv
src/eicc_ram.sv
src/eicc_datapath.sv
src/eicc_ctrl.sv
src/eeprom_image_crc_checker_core.sv
src/eicc_checker.sv
verif/tb_eeprom_image_crc_checker_core.sv
